### src/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
// Used by the front classifier, the back sequencer and the top level.
`default_nettype none

package tcce_pkg;

  localparam int CODE_W     = 8;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 7;
  localparam int COLS_W     = 9;
  localparam int ROWS_W     = 8;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACK    = 3'd4;

  // character codes
  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CODE_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    CMD_PRINT     = 3'd0,
    CMD_TAB       = 3'd1,
    CMD_NEWLINE   = 3'd2,
    CMD_RETURN    = 3'd3,
    CMD_BACKSPACE = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CODE_W-1:0] code;
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_BLANK  = 2'd1,
    ACT_SCROLL = 2'd2
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CODE_W-1:0] glyph;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

### src/tcce_front.sv
// Front of the cursor engine: accepts character items, drops the ones that
// do nothing, and queues commands for the back sequencer. Uses tcce_pkg.
`default_nettype none

module tcce_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        enable,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [tcce_pkg::CODE_W-1:0] char_code,
  output logic                       q_valid,
  input  wire                        q_ready,
  output tcce_pkg::cmd_t             q_cmd
);
  import tcce_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  cmd_t cmd_in;
  logic keep;
  logic push;
  logic pop;

  // classify the byte; control codes without a meaning are dropped
  always_comb begin
    cmd_in.code = char_code;
    cmd_in.kind = CMD_PRINT;
    keep        = 1'b1;
    priority if (char_code == CH_NEWLINE) begin
      cmd_in.kind = CMD_NEWLINE;
    end else if (char_code == CH_RETURN) begin
      cmd_in.kind = CMD_RETURN;
    end else if (char_code == CH_TAB) begin
      cmd_in.kind = CMD_TAB;
      cmd_in.code = CH_SPACE;
    end else if (char_code == CH_BACKSPACE) begin
      cmd_in.kind = CMD_BACKSPACE;
    end else if (char_code < CH_SPACE) begin
      keep = 1'b0;
    end else begin
      cmd_in.kind = CMD_PRINT;
    end
  end

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_cmd    = entries[rd_ptr];
  assign push     = in_valid && in_ready && enable && keep;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/tcce_back.sv
// Back of the cursor engine: holds the cursor and an output register, steps
// through each command one result per cycle while that register is free. Uses tcce_pkg.
`default_nettype none

module tcce_back #(
  parameter int TAB_STOP = 4
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  [tcce_pkg::COLS_W-1:0] eff_cols,
  input  wire  [tcce_pkg::ROWS_W-1:0] eff_rows,
  input  wire                         q_valid,
  output logic                        q_ready,
  input  wire  tcce_pkg::cmd_t        q_cmd,
  output logic                        out_valid,
  input  wire                         out_ready,
  output tcce_pkg::res_t              res
);
  import tcce_pkg::*;

  localparam int TW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_PRE     = 5'b00010,
    ST_DRAW    = 5'b00100,
    ST_NEWLINE = 5'b01000,
    ST_BACK    = 5'b10000
  } state_t;

  state_t            st, st_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  line, line_next;
  logic [TW-1:0]     tmod, tmod_next;
  logic [CODE_W-1:0] code, code_next;
  logic              is_tab, is_tab_next;
  logic              pre_wrapped, pre_wrapped_next;

  logic [COLS_W-1:0] col_inc;
  logic [ROWS_W-1:0] line_inc;
  logic [ROWS_W-1:0] rows_m1;
  logic              wrap;
  logic              col_past;
  logic              nl_scroll;
  logic [ROW_W-1:0]  nl_line;
  logic [TW-1:0]     tmod_inc;
  logic              more_tab;
  logic              slot_free;
  logic              want_emit;
  logic              step;
  res_t              res_new;

  assign col_inc   = {1'b0, col} + COLS_W'(1);
  assign line_inc  = {1'b0, line} + ROWS_W'(1);
  assign rows_m1   = eff_rows - ROWS_W'(1);
  assign wrap      = (col_inc >= eff_cols);
  assign col_past  = ({1'b0, col} >= eff_cols);
  assign nl_scroll = (line_inc >= eff_rows);
  assign nl_line   = nl_scroll ? rows_m1[ROW_W-1:0] : line_inc[ROW_W-1:0];
  assign tmod_inc  = (tmod == TW'(TAB_STOP - 1)) ? '0 : tmod + TW'(1);
  // tab keeps drawing until the column lands on a stop, and quits once wrapped
  assign more_tab  = is_tab && !pre_wrapped && !wrap && (tmod_inc != '0);
  assign slot_free = !out_valid || out_ready;
  assign step      = !want_emit || slot_free;
  assign q_ready   = (st == ST_IDLE);

  always_comb begin
    st_next          = st;
    col_next         = col;
    line_next        = line;
    tmod_next        = tmod;
    code_next        = code;
    is_tab_next      = is_tab;
    pre_wrapped_next = pre_wrapped;
    want_emit        = 1'b0;
    res_new.action   = ACT_SCROLL;
    res_new.col      = '0;
    res_new.row      = '0;
    res_new.glyph    = CH_SPACE;
    res_new.last     = 1'b1;

    unique case (st)
      ST_IDLE: begin
        if (q_valid) begin
          code_next        = q_cmd.code;
          is_tab_next      = (q_cmd.kind == CMD_TAB);
          pre_wrapped_next = 1'b0;
          unique case (q_cmd.kind)
            CMD_PRINT, CMD_TAB: begin
              st_next = col_past ? ST_PRE : ST_DRAW;
            end
            CMD_NEWLINE: begin
              st_next = ST_NEWLINE;
            end
            CMD_RETURN: begin
              col_next  = '0;
              tmod_next = '0;
            end
            CMD_BACKSPACE: begin
              if (col != '0) begin
                st_next = ST_BACK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PRE: begin
        // cursor sits past a shrunk right edge: new line before drawing
        want_emit    = nl_scroll;
        res_new.last = 1'b0;
        if (step) begin
          col_next         = '0;
          tmod_next        = '0;
          line_next        = nl_line;
          pre_wrapped_next = 1'b1;
          st_next          = ST_DRAW;
        end
      end
      ST_DRAW: begin
        want_emit      = 1'b1;
        res_new.action = ACT_DRAW;
        res_new.col    = col;
        res_new.row    = line;
        res_new.glyph  = code;
        res_new.last   = !(wrap && nl_scroll) && !more_tab;
        if (step) begin
          if (wrap) begin
            if (nl_scroll) begin
              st_next = ST_NEWLINE;
            end else begin
              col_next  = '0;
              tmod_next = '0;
              line_next = line_inc[ROW_W-1:0];
              st_next   = ST_IDLE;
            end
          end else begin
            col_next  = col_inc[COL_W-1:0];
            tmod_next = tmod_inc;
            st_next   = more_tab ? ST_DRAW : ST_IDLE;
          end
        end
      end
      ST_NEWLINE: begin
        want_emit = nl_scroll;
        if (step) begin
          col_next  = '0;
          tmod_next = '0;
          line_next = nl_line;
          st_next   = ST_IDLE;
        end
      end
      ST_BACK: begin
        want_emit      = 1'b1;
        res_new.action = ACT_BLANK;
        res_new.col    = col - COL_W'(1);
        res_new.row    = line;
        if (step) begin
          col_next  = col - COL_W'(1);
          tmod_next = (tmod == '0) ? TW'(TAB_STOP - 1) : tmod - TW'(1);
          st_next   = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      col       <= '0;
      line      <= '0;
      tmod      <= '0;
      out_valid <= 1'b0;
    end else begin
      st   <= st_next;
      col  <= col_next;
      line <= line_next;
      tmod <= tmod_next;
      if (want_emit && step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code        <= code_next;
    is_tab      <= is_tab_next;
    pre_wrapped <= pre_wrapped_next;
    if (want_emit && step) begin
      res <= res_new;
    end
  end

endmodule

`default_nettype wire

### src/text_console_cursor_engine_top.sv
// Text console cursor engine: turns a byte stream into draw, blank and
// scroll cell operations. Top level with configuration registers; uses
// tcce_pkg, tcce_front and tcce_back.
//
// The front takes one byte per cycle into a short command queue while there
// is room, dropping bytes that do nothing. The back sequencer takes a command
// only while idle, then walks its pre-wrap, draw, newline or backspace states,
// emitting at most one cell operation in each; a return is done at the fetch.
// A stalled output register holds the sequencer, not the front. Configuration
// registers are written through their own port with no wait; the user must
// write them only between items, as the block itself does not enforce this.
`default_nettype none

module text_console_cursor_engine_top #(
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 128,
  parameter int TAB_STOP    = 4,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [tcce_pkg::CODE_W-1:0]     char_code,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [1:0]                      action,
  output logic [tcce_pkg::COL_W-1:0]      cell_col,
  output logic [tcce_pkg::ROW_W-1:0]      cell_row,
  output logic [tcce_pkg::CODE_W-1:0]     glyph_code,
  output logic [tcce_pkg::COLOR_W-1:0]    cell_fore,
  output logic [tcce_pkg::COLOR_W-1:0]    cell_back,
  output logic                            last_result
);
  import tcce_pkg::*;

  logic               console_enable;
  logic [COLS_W-1:0]  column_count;
  logic [ROWS_W-1:0]  row_count;
  logic [COLOR_W-1:0] fore_color;
  logic [COLOR_W-1:0] back_color;
  logic [COLS_W-1:0]  eff_cols;
  logic [ROWS_W-1:0]  eff_rows;

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      console_enable <= 1'b0;
      column_count   <= COLS_W'(80);
      row_count      <= ROWS_W'(25);
      fore_color     <= '1;
      back_color     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:  console_enable <= cfg_data[0];
        REG_COLUMNS: column_count   <= cfg_data[COLS_W-1:0];
        REG_ROWS:    row_count      <= cfg_data[ROWS_W-1:0];
        REG_FORE:    fore_color     <= cfg_data[COLOR_W-1:0];
        REG_BACK:    back_color     <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the screen size: zero acts as one, oversize acts as the maximum
  always_comb begin
    priority if (column_count == '0) begin
      eff_cols = COLS_W'(1);
    end else if (column_count > COLS_W'(MAX_COLS)) begin
      eff_cols = COLS_W'(MAX_COLS);
    end else begin
      eff_cols = column_count;
    end
    priority if (row_count == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (row_count > ROWS_W'(MAX_ROWS)) begin
      eff_rows = ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = row_count;
    end
  end

  tcce_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .enable    (console_enable),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  tcce_back #(
    .TAB_STOP(TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_cols  (eff_cols),
    .eff_rows  (eff_rows),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // the user must not change colors while results are pending; the block does not enforce it
  assign action      = res.action;
  assign cell_col    = res.col;
  assign cell_row    = res.row;
  assign glyph_code  = res.glyph;
  assign last_result = res.last;
  assign cell_fore   = fore_color;
  assign cell_back   = back_color;

`ifndef SYNTHESIS
  a_scroll_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_SCROLL) |->
      (cell_col == '0 && cell_row == '0 && glyph_code == CH_SPACE))
    else $error("scroll result with nonzero cell or glyph");

  a_blank_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_BLANK) |-> last_result)
    else $error("blank result not marked last");

  a_follow_up: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_result) |=> out_valid)
    else $error("no result follows a result not marked last");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench for text_console_cursor_engine_top: directed and random byte streams,
// with a built-in predictor of cursor moves and cell operations.
// Depends on tcce_pkg and the engine RTL only.
`default_nettype none

module tb;
  import tcce_pkg::*;

  localparam int COL_LIMIT     = 256;
  localparam int ROW_LIMIT     = 128;
  localparam int TAB_PITCH     = 4;
  localparam int MAX_GAP       = 12;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    action_t              action;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [CODE_W-1:0]    glyph;
    logic [COLOR_W-1:0]   fore;
    logic [COLOR_W-1:0]   back;
    logic                 last;
  } cell_op_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CODE_W-1:0]     char_code;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            action;
  logic [COL_W-1:0]      cell_col;
  logic [ROW_W-1:0]      cell_row;
  logic [CODE_W-1:0]     glyph_code;
  logic [COLOR_W-1:0]    cell_fore;
  logic [COLOR_W-1:0]    cell_back;
  logic                  last_result;

  text_console_cursor_engine_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .action      (action),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .glyph_code  (glyph_code),
    .cell_fore   (cell_fore),
    .cell_back   (cell_back),
    .last_result (last_result)
  );

  // predictor copy of the registers and the cursor
  logic               cfg_enable;
  logic [COLS_W-1:0]  cfg_cols;
  logic [ROWS_W-1:0]  cfg_rows;
  logic [COLOR_W-1:0] cfg_fore;
  logic [COLOR_W-1:0] cfg_back;
  int unsigned        cur_col;
  int unsigned        cur_line;

  cell_op_t cells_due[$];
  cell_op_t got;
  cell_op_t want;
  int       mismatches    = 0;
  int       results_taken = 0;
  int       cycle_count   = 0;
  bit       in_calm;
  bit       out_calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned cols_in_use();
    int unsigned c;
    c = cfg_cols;
    if (c == 0) c = 1;
    if (c > COL_LIMIT) c = COL_LIMIT;
    return c;
  endfunction

  function automatic int unsigned rows_in_use();
    int unsigned r;
    r = cfg_rows;
    if (r == 0) r = 1;
    if (r > ROW_LIMIT) r = ROW_LIMIT;
    return r;
  endfunction

  function automatic void queue_op(action_t act, int unsigned col, int unsigned row,
                                   logic [CODE_W-1:0] glyph);
    cells_due.push_back('{act, COL_W'(col), ROW_W'(row), glyph, cfg_fore, cfg_back, 1'b0});
  endfunction

  function automatic void line_feed();
    int unsigned line;
    line = cur_line + 1;
    cur_col = 0;
    if (line >= rows_in_use()) begin
      queue_op(ACT_SCROLL, 0, 0, CH_SPACE);
      line = rows_in_use() - 1;
    end
    cur_line = line & 'h7F;
  endfunction

  // returns 1 when the line wrapped while drawing
  function automatic bit draw_char(logic [CODE_W-1:0] glyph);
    int unsigned cols;
    bit wrapped;
    cols = cols_in_use();
    wrapped = 1'b0;
    if (cur_col >= cols) begin
      line_feed();
      wrapped = 1'b1;
    end
    queue_op(ACT_DRAW, cur_col, cur_line, glyph);
    if (cur_col + 1 >= cols) begin
      line_feed();
      wrapped = 1'b1;
    end else begin
      cur_col = cur_col + 1;
    end
    return wrapped;
  endfunction

  function automatic void predict_char(logic [CODE_W-1:0] code);
    int          first;
    int unsigned stop;
    first = cells_due.size();
    if (!cfg_enable) return;
    case (code)
      CH_NEWLINE: line_feed();
      CH_RETURN: cur_col = 0;
      CH_TAB: begin
        stop = (cur_col / TAB_PITCH + 1) * TAB_PITCH;
        while (cur_col < stop)
          if (draw_char(CH_SPACE)) break;
      end
      CH_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col = cur_col - 1;
          queue_op(ACT_BLANK, cur_col, cur_line, CH_SPACE);
        end
      end
      default: begin
        if (code >= CH_SPACE) void'(draw_char(code));
      end
    endcase
    if (cells_due.size() > first) cells_due[cells_due.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_char(logic [CODE_W-1:0] code);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(code);
  endtask

  // drop valid, drain every due cell op, then let queued no-op items retire
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENABLE:  cfg_enable = data[0];
      REG_COLUMNS: cfg_cols   = data[COLS_W-1:0];
      REG_ROWS:    cfg_rows   = data[ROWS_W-1:0];
      REG_FORE:    cfg_fore   = data;
      REG_BACK:    cfg_back   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // fill the bits above a register's width with junk
  function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] value,
                                                       int width);
    return ($urandom() << width) | value;
  endfunction

  task automatic configure(bit enable, int unsigned cols, int unsigned rows,
                           logic [COLOR_W-1:0] fore, logic [COLOR_W-1:0] back);
    wait_idle();
    set_reg(REG_ENABLE, with_noise(CFG_DATA_W'(enable), 1));
    set_reg(REG_COLUMNS, with_noise(CFG_DATA_W'(cols), COLS_W));
    set_reg(REG_ROWS, with_noise(CFG_DATA_W'(rows), ROWS_W));
    set_reg(REG_FORE, fore);
    set_reg(REG_BACK, back);
  endtask

  function automatic logic [CODE_W-1:0] pick_char(input int w_print, input int w_tab,
                                                  input int w_nl, input int w_cr,
                                                  input int w_bs, input int w_misc);
    int roll;
    logic [CODE_W-1:0] code;
    roll = $urandom_range(0, w_print + w_tab + w_nl + w_cr + w_bs + w_misc - 1);
    if (roll < w_print) return CODE_W'($urandom_range(32, 255));
    roll -= w_print;
    if (roll < w_tab) return CH_TAB;
    roll -= w_tab;
    if (roll < w_nl) return CH_NEWLINE;
    roll -= w_nl;
    if (roll < w_cr) return CH_RETURN;
    roll -= w_cr;
    if (roll < w_bs) return CH_BACKSPACE;
    do code = CODE_W'($urandom_range(0, 31));
    while (code == CH_BACKSPACE || code == CH_TAB || code == CH_NEWLINE ||
           code == CH_RETURN);
    return code;
  endfunction

  task automatic type_text(int count, int w_print, int w_tab, int w_nl, int w_cr,
                           int w_bs, int w_misc, int pause_every);
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      if (pause_every > 0 && i > 0 && i % pause_every == 0) wait_idle();
      send_char(pick_char(w_print, w_tab, w_nl, w_cr, w_bs, w_misc));
    end
  endtask

  // result side: stall a random number of cycles before each cell op
  initial begin
    int stall;
    int seen;
    stall = 3;
    seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (results_taken != seen) begin
        seen = results_taken;
        stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_taken++;
      got = '{action_t'(action), cell_col, cell_row, glyph_code, cell_fore, cell_back,
              last_result};
      if (cells_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected cell op at cycle %0d: act %0d col %0d row %0d glyph %h",
                   cycle_count, got.action, got.col, got.row, got.glyph);
      end else begin
        want = cells_due.pop_front();
        if (got.action !== want.action || got.col !== want.col || got.row !== want.row ||
            got.glyph !== want.glyph || got.fore !== want.fore || got.back !== want.back ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("cell op mismatch at cycle %0d", cycle_count);
            $display("  expected act %0d col %0d row %0d glyph %h fore %h back %h last %b",
                     want.action, want.col, want.row, want.glyph, want.fore, want.back,
                     want.last);
            $display("  actual   act %0d col %0d row %0d glyph %h fore %h back %h last %b",
                     got.action, got.col, got.row, got.glyph, got.fore, got.back, got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // engine comes out of reset disabled: bytes are swallowed, cursor holds
  task automatic test_disabled();
    send_char(8'h41);
    send_char(CH_TAB);
    send_char(CH_NEWLINE);
    wait_idle();
    set_reg(REG_ENABLE, 32'd1);
  endtask

  task automatic test_printables();
    send_char(CH_SPACE);
    send_char(8'h7E);
    send_char(8'hFF);
    send_char(8'h80);
  endtask

  task automatic test_controls();
    send_char(CH_BACKSPACE);
    send_char(CH_RETURN);
    send_char(CH_BACKSPACE);   // at column zero: no op
    send_char(CH_TAB);
    send_char(8'h78);
    send_char(CH_TAB);
    send_char(8'h00);
    send_char(8'h1F);
    send_char(8'h0B);
    send_char(CH_NEWLINE);
  endtask

  // zero columns and rows act as one: every byte scrolls, and each drawn one wraps
  task automatic test_tiny_screen();
    wait_idle();
    set_reg(REG_COLUMNS, 32'd0);
    set_reg(REG_ROWS, 32'd0);
    set_reg(REG_FORE, 32'h0000_0000);
    set_reg(REG_BACK, 32'hFFFF_FFFF);
    send_char(8'h5A);
    send_char(CH_TAB);
    send_char(CH_NEWLINE);
  endtask

  // oversize counts clamp; shrinking the width under the cursor forces a new line
  task automatic test_shrink_width();
    wait_idle();
    set_reg(REG_COLUMNS, 32'd511);
    set_reg(REG_ROWS, 32'd255);
    send_char(8'h61);
    send_char(8'h62);
    send_char(8'h63);
    wait_idle();
    set_reg(REG_COLUMNS, 32'd2);
    send_char(8'h64);
    send_char(CH_BACKSPACE);
  endtask

  // full width, mostly tabs, so the cursor runs out to the last column
  task automatic test_long_lines();
    configure(1'b1, COL_LIMIT, $urandom_range(1, 4), $urandom(), $urandom());
    type_text(90, 12, 84, 0, 0, 2, 2, 0);
  endtask

  // one column, full height: walk the cursor down to the last row and scroll
  task automatic test_many_rows();
    configure(1'b1, 1, ROW_LIMIT, $urandom(), $urandom());
    type_text(150, 35, 10, 49, 2, 2, 2, 0);
  endtask

  task automatic test_mixed_screens();
    int unsigned cols;
    int unsigned rows;
    for (int round = 0; round < 4; round++) begin
      case ($urandom_range(0, 5))
        0: cols = 0;
        1: cols = $urandom_range(COL_LIMIT + 1, 511);
        default: cols = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 5))
        0: rows = 0;
        1: rows = $urandom_range(ROW_LIMIT + 1, 255);
        default: rows = $urandom_range(1, 10);
      endcase
      configure(1'b1, cols, rows, $urandom(), $urandom());
      type_text(10, 45, 15, 12, 6, 14, 8, 5);
      if (round == 1) begin
        configure(1'b0, cols, rows, $urandom(), $urandom());
        type_text(10, 45, 15, 12, 6, 14, 8, 0);
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ENABLE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    char_code <= '0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    cfg_enable = 1'b0;
    cfg_cols   = 9'd80;
    cfg_rows   = 8'd25;
    cfg_fore   = 32'hFFFF_FFFF;
    cfg_back   = 32'h0000_0000;
    cur_col    = 0;
    cur_line   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_disabled();
    test_printables();
    test_controls();
    test_tiny_screen();
    test_shrink_width();
    test_long_lines();
    test_many_rows();
    test_mixed_screens();
    wait_idle();

    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### text_console_cursor_engine_top.f
src/tcce_pkg.sv
src/tcce_front.sv
src/tcce_back.sv
src/text_console_cursor_engine_top.sv
dv/tb.sv
